// ----- design/bif_pkg.sv -----
package bif_pkg;

   // Default build of the filter
   localparam int TAPS_DEF       = 9;
   localparam int STATE_BITS_DEF = 40;
   localparam int COEF_BITS_DEF  = 27;

   // Table format: fractional bits and number of b (or a) entries
   localparam int TAB_FRAC = 22;
   localparam int TAB_LEN  = 9;

   // Reset value of band_select
   localparam logic BAND_RESET = 1'b1;

   // [set][0..8] = b, [set][9..17] = a, a[0] unused; Q5.22
   localparam int COEF_TAB [2][18] = '{
      '{ 42822, 0, -171287, 0, 256930, 0, -171287, 0, 42822,
         4194304, -19159735, 41772017, -56619438, 52176272, -33344620,
         14418363, -3871572, 504951 },
      '{ 571271, 0, -2285085, 0, 3427628, 0, -2285085, 0, 571271,
         4194304, 10944432, 9753981, 5044180, 4684627, 3194150,
         419645, -54454, 93819 }
   };

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEEDBACK,
      ST_FB_DRAIN,
      ST_ROUND_W,
      ST_FEEDFWD,
      ST_FF_DRAIN,
      ST_ROUND_Y
   } bif_state_type;

   // Control of the shared multiply-accumulate unit
   typedef struct packed {
      logic load;
      logic mul_en;
      logic hi_part;
      logic subtract;
   } mac_ctl_type;

   // Coefficient for one tap, rescaled to cbits with cbits-5 fractional bits.
   // Taps past the table read as zero.
   function automatic logic signed [31:0] coef_value(input logic set, input logic is_a,
                                                      input int tap, input int cbits);
      longint raw;
      longint scaled;
      int     frac;
      if (tap >= TAB_LEN) begin
         return '0;
      end
      raw  = longint'(COEF_TAB[set][is_a ? tap + TAB_LEN : tap]);
      frac = cbits - 5;
      if (frac >= TAB_FRAC) begin
         scaled = raw <<< (frac - TAB_FRAC);
      end else begin
         scaled = (raw + (longint'(1) <<< (TAB_FRAC - frac - 1))) >>> (TAB_FRAC - frac);
      end
      return 32'(scaled);
   endfunction

endpackage

// ----- design/bandpass_iir_filter.sv -----
// Eighth-order direct form II Butterworth bandpass on Q1.15 samples. band_select picks
// the 1-3 kHz set (0) or the 3-7.5 kHz set (1, reset value); write it only while idle.
// A result is posted from the output rounding state after the feedback and output sums.
// The next sample can transfer only once the block is back in idle, so a sample is done
// before the next one is taken. One shared multiplier forms every coefficient-by-state
// product as two half-word partial products, first the feedback sum, then the output
// sum, each with a drain and a round state. req_stall is high for that whole time; the
// result waits in an output register, so the next sample is taken while it is still
// stalled. If that result is still stalled when the next item finishes, the next item
// holds in its last cycle. start_of_signal clears the delay line before the sample is
// filtered. saturated flags a clip of the new state or the output.
module bandpass_iir_filter #(
   parameter int TAPS       = bif_pkg::TAPS_DEF,
   parameter int STATE_BITS = bif_pkg::STATE_BITS_DEF,
   parameter int COEF_BITS  = bif_pkg::COEF_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_in,
   input  logic               req_start_of_signal,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_filtered_sample,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);
   import bif_pkg::*;

   localparam int CFRAC    = COEF_BITS - 5;
   localparam int HI_SHIFT = STATE_BITS / 2;
   localparam int OP_BITS  = STATE_BITS - HI_SHIFT + 1;
   localparam int ACC_BITS = COEF_BITS + STATE_BITS + 6;
   localparam int X_SHIFT  = COEF_BITS + 4;
   localparam int Y_SHIFT  = CFRAC + 9;
   localparam int CNT_BITS = $clog2(2 * TAPS);
   localparam int DL_DEPTH = TAPS - 1;
   localparam int DL_BITS  = $clog2(DL_DEPTH);
   localparam int FB_LAST  = 2 * (TAPS - 1) - 1;
   localparam int FF_LAST  = 2 * TAPS - 1;

   bif_state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                        band_ff;
   logic signed [STATE_BITS-1:0] delay_ff [DL_DEPTH];
   logic signed [STATE_BITS-1:0] w0_ff;
   logic                        clip_ff;
   logic                        rsp_valid_ff;
   logic signed [15:0]          rsp_sample_ff;
   logic                        rsp_sat_ff;

   mac_ctl_type                 ctl;
   logic [CNT_BITS-2:0]         tap, tap_m1;
   logic [CNT_BITS-1:0]         coef_idx;
   logic                        is_a;
   logic                        use_w0;
   logic [DL_BITS-1:0]          dl_idx;
   logic signed [STATE_BITS-1:0] src;
   logic signed [OP_BITS-1:0]   operand;
   logic signed [COEF_BITS-1:0] coef;
   logic signed [ACC_BITS-1:0]  load_value;
   logic signed [ACC_BITS-1:0]  acc;
   logic                        accept;
   logic                        out_free;

   logic signed [ACC_BITS-1:0]  w_rnd, w_sh, y_rnd, y_sh;
   logic                        w_ok, y_ok;
   logic signed [STATE_BITS-1:0] w_val;
   logic signed [15:0]          y_val;

   assign tap      = cnt_ff[CNT_BITS-1:1];
   assign tap_m1   = tap - 1'b1;
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer: next state and unit control
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctl      = '0;
      is_a     = 1'b0;
      use_w0   = 1'b0;
      coef_idx = CNT_BITS'(tap);
      dl_idx   = tap[DL_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_FEEDBACK;
            end
         end
         ST_FEEDBACK: begin
            ctl.mul_en   = 1'b1;
            ctl.hi_part  = cnt_ff[0];
            ctl.subtract = 1'b1;
            is_a         = 1'b1;
            coef_idx     = CNT_BITS'(tap) + 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(FB_LAST)) begin
               state_in = ST_FB_DRAIN;
            end
         end
         ST_FB_DRAIN: begin
            state_in = ST_ROUND_W;
         end
         ST_ROUND_W: begin
            ctl.load = 1'b1;
            cnt_in   = '0;
            state_in = ST_FEEDFWD;
         end
         ST_FEEDFWD: begin
            ctl.mul_en  = 1'b1;
            ctl.hi_part = cnt_ff[0];
            use_w0      = (tap == '0);
            dl_idx      = tap_m1[DL_BITS-1:0];
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(FF_LAST)) begin
               state_in = ST_FF_DRAIN;
            end
         end
         ST_FF_DRAIN: begin
            state_in = ST_ROUND_Y;
         end
         ST_ROUND_Y: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Select operand half and coefficient
   always_comb begin
      src     = use_w0 ? w0_ff : delay_ff[dl_idx];
      operand = ctl.hi_part ? $signed({src[STATE_BITS-1], src[STATE_BITS-1:HI_SHIFT]})
                            : $signed(OP_BITS'({1'b0, src[HI_SHIFT-1:0]}));
      coef    = COEF_BITS'(coef_value(band_ff, is_a, int'(coef_idx), COEF_BITS));
   end

   // Input sample scaled into the accumulator, or zero for the output sum
   assign load_value = (state_ff == ST_IDLE)
                     ? $signed({{(ACC_BITS - 16 - X_SHIFT){req_sample_in[15]}},
                                req_sample_in, {X_SHIFT{1'b0}}})
                     : '0;

   bif_mac #(
      .COEF_BITS (COEF_BITS),
      .OP_BITS   (OP_BITS),
      .ACC_BITS  (ACC_BITS),
      .HI_SHIFT  (HI_SHIFT)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .coef_in    (coef),
      .operand_in (operand),
      .load_value (load_value),
      .acc        (acc)
   );

   // Round half up and saturate the new state and the output
   always_comb begin
      w_rnd = acc + (ACC_BITS'(1) <<< (CFRAC - 1));
      w_sh  = w_rnd >>> CFRAC;
      w_ok  = (&w_sh[ACC_BITS-1:STATE_BITS-1]) || !(|w_sh[ACC_BITS-1:STATE_BITS-1]);
      if (w_ok) begin
         w_val = w_sh[STATE_BITS-1:0];
      end else begin
         w_val = w_sh[ACC_BITS-1] ? $signed({1'b1, {(STATE_BITS-1){1'b0}}})
                                  : $signed({1'b0, {(STATE_BITS-1){1'b1}}});
      end
      y_rnd = acc + (ACC_BITS'(1) <<< (Y_SHIFT - 1));
      y_sh  = y_rnd >>> Y_SHIFT;
      y_ok  = (&y_sh[ACC_BITS-1:15]) || !(|y_sh[ACC_BITS-1:15]);
      if (y_ok) begin
         y_val = y_sh[15:0];
      end else begin
         y_val = y_sh[ACC_BITS-1] ? 16'sh8000 : 16'sh7fff;
      end
   end

   // Control state, band register and delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         band_ff      <= BAND_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DL_DEPTH; i++) begin
            delay_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_write_enable) begin
            band_ff <= csr_write_data;
         end
         // clear history on a start-of-signal transfer
         if (accept && req_start_of_signal) begin
            for (int i = 0; i < DL_DEPTH; i++) begin
               delay_ff[i] <= '0;
            end
         end
         // advance the delay line when the result is posted
         if ((state_ff == ST_ROUND_Y) && out_free) begin
            delay_ff[0] <= w0_ff;
            for (int i = 1; i < DL_DEPTH; i++) begin
               delay_ff[i] <= delay_ff[i-1];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROUND_W) begin
         w0_ff   <= w_val;
         clip_ff <= !w_ok;
      end
      if ((state_ff == ST_ROUND_Y) && out_free) begin
         rsp_sample_ff <= y_val;
         rsp_sat_ff    <= clip_ff || !y_ok;
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

// ----- design/bif_mac.sv -----
module bif_mac #(
   parameter int COEF_BITS = bif_pkg::COEF_BITS_DEF,
   parameter int OP_BITS   = bif_pkg::STATE_BITS_DEF / 2 + 1,
   parameter int ACC_BITS  = bif_pkg::COEF_BITS_DEF + bif_pkg::STATE_BITS_DEF + 6,
   parameter int HI_SHIFT  = bif_pkg::STATE_BITS_DEF / 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bif_pkg::mac_ctl_type        ctl,
   input  logic signed [COEF_BITS-1:0] coef_in,
   input  logic signed [OP_BITS-1:0]   operand_in,
   input  logic signed [ACC_BITS-1:0]  load_value,
   output logic signed [ACC_BITS-1:0]  acc
);
   import bif_pkg::*;

   localparam int PROD_BITS = COEF_BITS + OP_BITS;

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic                        pv_ff, hi_ff, sub_ff;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]  ext;
   logic signed [ACC_BITS-1:0]  term;

   // Multiply stage
   assign prod_in = PROD_BITS'(coef_in) * PROD_BITS'(operand_in);

   // Align the partial product and accumulate
   always_comb begin
      ext  = ACC_BITS'(prod_ff);
      term = hi_ff ? (ext <<< HI_SHIFT) : ext;
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = load_value;
      end else if (pv_ff) begin
         acc_in = sub_ff ? (acc_ff - term) : (acc_ff + term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctl.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      hi_ff   <= ctl.hi_part;
      sub_ff  <= ctl.subtract;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- design/bif_checker.sv -----
module bif_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_filtered_sample,
   input logic        rsp_saturated
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_sample)
                                 && $stable(rsp_saturated))
      else $error("stalled result changed");

   // A sample transfer makes the block busy
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("not busy after a sample transfer");

   // A new result is only posted from work in progress
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result posted while idle");

endmodule

bind bandpass_iir_filter bif_checker u_checker (.*);
